FILE: hw/rtl/bs_pkg.sv
// shared constants, types and codes for the bucket sorter
package bs_pkg;

    localparam int CAPACITY    = 64;
    localparam int MAX_BUCKETS = 16;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int BCFG_W   = 5;
    localparam int SPAN_W   = 16;
    localparam int BEFF_W   = $clog2(MAX_BUCKETS + 1);
    localparam int LIMIT_W  = BEFF_W + SPAN_W;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [BCFG_W-1:0] BUCKET_COUNT_RESET = BCFG_W'(10);
    localparam logic [SPAN_W-1:0] BUCKET_SPAN_RESET  = SPAN_W'(10);

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SPAN  = CFG_IDX_W'(1);

    localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = STATUS_W'(2);

    typedef enum logic [1:0] {
        S_LOAD,
        S_DRAIN,
        S_ERROR
    } t_state;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/bs_cell.sv
// one cell of the sorted insertion chain
module bs_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bs_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [bs_pkg::VALUE_W-1:0] i_sample,
    input  logic signed [bs_pkg::VALUE_W-1:0] i_left_value,
    input  logic                              i_left_valid,
    input  logic                              i_left_greater,
    input  logic signed [bs_pkg::VALUE_W-1:0] i_right_value,
    input  logic                              i_right_valid,
    output logic signed [bs_pkg::VALUE_W-1:0] o_value,
    output logic                              o_valid,
    output logic                              o_greater
);

    logic signed [bs_pkg::VALUE_W-1:0] r_value;
    logic                              r_valid;
    logic signed [bs_pkg::VALUE_W-1:0] n_value;
    logic                              n_valid;

    // an empty cell counts as above every value
    assign o_greater = !r_valid || (r_value > i_sample);
    assign o_value   = r_value;
    assign o_valid   = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctl.insert && o_greater) begin
            // stable: the new value lands after every stored value not above it
            if (i_left_greater) begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else begin
                n_value = i_sample;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: hw/rtl/bucket_sorter.sv
// bucket sorter top level: control, limit check and the insertion cell chain
//
// Values are loaded one per clock: while busy is low, each start pulse inserts i_sample into
// a chain of CAPACITY sorted cells, so loading runs at one value per cycle. After the value
// flagged final, busy stays high while the chain shifts its contents out of cell 0, one
// result per cycle, or while a single error result is sent. Results are registered and show
// on the outputs in the cycle after they are sent, each for exactly one cycle with o_valid
// high; the receiver cannot stall them and must take every one. A value above
// bucket_count*bucket_span, with the count clamped to 1..MAX_BUCKETS and the span to at
// least 1 (status 1), or a value that finds the store full (status 2) ends the run in one
// error result that carries the first offending value; later values of that run are
// ignored. Configuration writes belong in idle time between runs.
module bucket_sorter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [bs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [bs_pkg::VALUE_W-1:0]   i_sample,
    input  logic                                i_final_item,
    output logic                                o_valid,
    output logic signed [bs_pkg::VALUE_W-1:0]   o_sorted_value,
    output logic                                o_final_result,
    output logic [bs_pkg::STATUS_W-1:0]         o_status
);

    localparam int N = bs_pkg::CAPACITY;

    logic [bs_pkg::BCFG_W-1:0]   r_bucket_count;
    logic [bs_pkg::SPAN_W-1:0]   r_bucket_span;

    bs_pkg::t_state              r_state;
    bs_pkg::t_state              n_state;
    logic [bs_pkg::COUNT_W-1:0]  r_count;
    logic [bs_pkg::COUNT_W-1:0]  n_count;
    logic [bs_pkg::STATUS_W-1:0] r_err;
    logic [bs_pkg::STATUS_W-1:0] n_err;
    logic signed [bs_pkg::VALUE_W-1:0] r_bad;
    logic signed [bs_pkg::VALUE_W-1:0] n_bad;

    logic                              r_out_valid;
    logic                              n_out_valid;
    logic signed [bs_pkg::VALUE_W-1:0] r_out_value;
    logic signed [bs_pkg::VALUE_W-1:0] n_out_value;
    logic                              r_out_final;
    logic                              n_out_final;
    logic [bs_pkg::STATUS_W-1:0]       r_out_status;
    logic [bs_pkg::STATUS_W-1:0]       n_out_status;

    bs_pkg::t_cell_ctl           cell_ctl;

    logic                        accept;
    logic [bs_pkg::BEFF_W-1:0]   buckets_eff;
    logic [bs_pkg::SPAN_W-1:0]   span_eff;
    logic [bs_pkg::LIMIT_W-1:0]  limit;
    logic signed [bs_pkg::VALUE_W:0] sample_ext;
    logic signed [bs_pkg::VALUE_W:0] limit_ext;
    logic                        too_big;
    logic                        too_many;
    logic                        store_ok;

    logic signed [bs_pkg::VALUE_W-1:0] cell_value   [N];
    logic                              cell_valid   [N];
    logic                              cell_greater [N];

    assign busy   = (r_state != bs_pkg::S_LOAD);
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= bs_pkg::BUCKET_COUNT_RESET;
            r_bucket_span  <= bs_pkg::BUCKET_SPAN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bs_pkg::REG_BUCKET_COUNT: r_bucket_count <= i_cfg_data[bs_pkg::BCFG_W-1:0];
                bs_pkg::REG_BUCKET_SPAN:  r_bucket_span  <= i_cfg_data[bs_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // upper bound of the last bucket in use
    always_comb begin
        if (r_bucket_count == '0) begin
            buckets_eff = bs_pkg::BEFF_W'(1);
        end else if (32'(r_bucket_count) > bs_pkg::MAX_BUCKETS) begin
            buckets_eff = bs_pkg::BEFF_W'(bs_pkg::MAX_BUCKETS);
        end else begin
            buckets_eff = bs_pkg::BEFF_W'(r_bucket_count);
        end
        span_eff = (r_bucket_span == '0) ? bs_pkg::SPAN_W'(1) : r_bucket_span;
    end

    assign limit      = bs_pkg::LIMIT_W'(buckets_eff) * bs_pkg::LIMIT_W'(span_eff);
    assign sample_ext = {i_sample[bs_pkg::VALUE_W-1], i_sample};
    assign limit_ext  = $signed({1'b0, bs_pkg::VALUE_W'(limit)});
    assign too_big    = sample_ext > limit_ext;
    assign too_many   = (r_count == bs_pkg::COUNT_W'(N));
    assign store_ok   = accept && (r_err == bs_pkg::ST_OK) && !too_big && !too_many;

    // error capture: the first error of a run is kept with its value
    always_comb begin
        n_err = r_err;
        n_bad = r_bad;
        if (accept && (r_err == bs_pkg::ST_OK)) begin
            if (too_big) begin
                n_err = bs_pkg::ST_TOO_BIG;
                n_bad = i_sample;
            end else if (too_many) begin
                n_err = bs_pkg::ST_TOO_MANY;
                n_bad = i_sample;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bs_pkg::S_LOAD: begin
                if (accept && i_final_item) begin
                    n_state = (n_err != bs_pkg::ST_OK) ? bs_pkg::S_ERROR : bs_pkg::S_DRAIN;
                end
            end
            bs_pkg::S_DRAIN: begin
                if (r_count == bs_pkg::COUNT_W'(1)) begin
                    n_state = bs_pkg::S_LOAD;
                end
            end
            bs_pkg::S_ERROR: n_state = bs_pkg::S_LOAD;
            default:         n_state = bs_pkg::S_LOAD;
        endcase
    end

    // outputs, chain control and run bookkeeping
    always_comb begin
        cell_ctl     = '0;
        n_count      = r_count;
        n_out_valid  = 1'b0;
        n_out_value  = cell_value[0];
        n_out_final  = 1'b0;
        n_out_status = bs_pkg::ST_OK;
        case (r_state)
            bs_pkg::S_LOAD: begin
                cell_ctl.insert = store_ok;
                if (store_ok) begin
                    n_count = r_count + bs_pkg::COUNT_W'(1);
                end
            end
            bs_pkg::S_DRAIN: begin
                cell_ctl.shift = 1'b1;
                n_count        = r_count - bs_pkg::COUNT_W'(1);
                n_out_valid    = 1'b1;
                n_out_final    = (r_count == bs_pkg::COUNT_W'(1));
            end
            bs_pkg::S_ERROR: begin
                cell_ctl.clear = 1'b1;
                n_count        = '0;
                n_out_valid    = 1'b1;
                n_out_value    = r_bad;
                n_out_final    = 1'b1;
                n_out_status   = r_err;
            end
            default: begin
                cell_ctl.clear = 1'b1;
                n_count        = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bs_pkg::S_LOAD;
            r_count     <= '0;
            r_err       <= bs_pkg::ST_OK;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            // the error capture is cleared while a run sends its results, ready for the next run
            if (r_state != bs_pkg::S_LOAD) begin
                r_err <= bs_pkg::ST_OK;
                r_bad <= '0;
            end else begin
                r_err <= n_err;
                r_bad <= n_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_final  <= n_out_final;
        r_out_status <= n_out_status;
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_final_result = r_out_final;
    assign o_status       = r_out_status;

    // insertion chain: each value lands at its sorted place, larger values move right; results leave from cell 0
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic signed [bs_pkg::VALUE_W-1:0] left_value;
        logic                              left_valid;
        logic                              left_greater;
        logic signed [bs_pkg::VALUE_W-1:0] right_value;
        logic                              right_valid;

        if (i == 0) begin : g_first
            assign left_value   = '0;
            assign left_valid   = 1'b0;
            assign left_greater = 1'b0;
        end else begin : g_inner_left
            assign left_value   = cell_value[i-1];
            assign left_valid   = cell_valid[i-1];
            assign left_greater = cell_greater[i-1];
        end

        if (i == N - 1) begin : g_last
            assign right_value = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner_right
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        bs_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (cell_ctl),
            .i_sample       (i_sample),
            .i_left_value   (left_value),
            .i_left_valid   (left_valid),
            .i_left_greater (left_greater),
            .i_right_value  (right_value),
            .i_right_valid  (right_valid),
            .o_value        (cell_value[i]),
            .o_valid        (cell_valid[i]),
            .o_greater      (cell_greater[i])
        );
    end

endmodule
